FILE: hw/rtl/tdlca_pkg.sv
package tdlca_pkg;

    localparam int NODES     = 1024;
    localparam int LEVELS    = 10;
    localparam int NODE_W    = 10;
    localparam int DEP_W     = 10;
    localparam int ANC_W     = NODE_W + 1;
    localparam int NODE_AW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LV_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_DEPTH = NODES * LEVELS;
    localparam int ANC_AW    = (ANC_DEPTH > 1) ? $clog2(ANC_DEPTH) : 1;
    localparam int PC_W      = 4;

    localparam logic [LV_W-1:0] LV_TOP = LV_W'(LEVELS - 1);

    // item actions
    localparam logic ACT_ATTACH = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic [DEP_W-1:0]  distance;
        logic [NODE_W-1:0] common_ancestor;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
    } t_anc;

    // microprogram step addresses
    localparam logic [PC_W-1:0] S_A_RD     = 4'd0;
    localparam logic [PC_W-1:0] S_A_DEP    = 4'd1;
    localparam logic [PC_W-1:0] S_A_LOOP   = 4'd2;
    localparam logic [PC_W-1:0] S_A_END    = 4'd3;
    localparam logic [PC_W-1:0] S_Q_RDA    = 4'd4;
    localparam logic [PC_W-1:0] S_Q_RDB    = 4'd5;
    localparam logic [PC_W-1:0] S_Q_SWAP   = 4'd6;
    localparam logic [PC_W-1:0] S_Q_LIFT   = 4'd7;
    localparam logic [PC_W-1:0] S_Q_JSET   = 4'd8;
    localparam logic [PC_W-1:0] S_Q_JOINT  = 4'd9;
    localparam logic [PC_W-1:0] S_Q_FINAL  = 4'd10;
    localparam logic [PC_W-1:0] S_Q_DIST   = 4'd11;

    // depth read node select
    localparam logic [1:0] DS_A     = 2'd0;
    localparam logic [1:0] DS_B     = 2'd1;
    localparam logic [1:0] DS_UNEXT = 2'd2;
    localparam logic [1:0] DS_CNEXT = 2'd3;

    // ancestor port U read node select
    localparam logic [1:0] US_PARENT = 2'd0;
    localparam logic [1:0] US_CHAIN  = 2'd1;
    localparam logic [1:0] US_NEXT   = 2'd2;

    // ancestor read level select
    localparam logic [1:0] LS_ZERO = 2'd0;
    localparam logic [1:0] LS_LV   = 2'd1;
    localparam logic [1:0] LS_TOP  = 2'd2;
    localparam logic [1:0] LS_NEXT = 2'd3;

    // node register update
    localparam logic [1:0] UO_HOLD  = 2'd0;
    localparam logic [1:0] UO_SWAP  = 2'd1;
    localparam logic [1:0] UO_LIFT  = 2'd2;
    localparam logic [1:0] UO_JOINT = 2'd3;

    // level counter update
    localparam logic [2:0] LO_HOLD = 3'd0;
    localparam logic [2:0] LO_ZERO = 3'd1;
    localparam logic [2:0] LO_TOP  = 3'd2;
    localparam logic [2:0] LO_INC  = 3'd3;
    localparam logic [2:0] LO_DEC  = 3'd4;

    // ancestor result update
    localparam logic [1:0] CO_HOLD = 2'd0;
    localparam logic [1:0] CO_U    = 2'd1;
    localparam logic [1:0] CO_FIN  = 2'd2;

    // jump conditions
    localparam logic [2:0] JC_NONE    = 3'd0;
    localparam logic [2:0] JC_LV_NZ   = 3'd1;
    localparam logic [2:0] JC_LV_TOP  = 3'd2;
    localparam logic [2:0] JC_LV_NTOP = 3'd3;
    localparam logic [2:0] JC_SAME    = 3'd4;

    typedef struct packed {
        logic            d_re;
        logic [1:0]      dsel;
        logic            d_we;
        logic            a_we;
        logic            a_wchain;
        logic            u_re;
        logic [1:0]      usel;
        logic            v_re;
        logic [1:0]      lsel;
        logic [1:0]      uop;
        logic [2:0]      lvop;
        logic [1:0]      cop;
        logic            cap_da;
        logic            pv_init;
        logic            pv_chain;
        logic            emit;
        logic            fin;
        logic [2:0]      jc;
        logic [PC_W-1:0] jt;
    } t_uop;

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop w;
        w = '0;
        unique case (pc)
            S_A_RD: begin
                w.d_re = 1'b1; w.dsel = DS_B; w.lvop = LO_ZERO;
            end
            S_A_DEP: begin
                w.d_we = 1'b1; w.a_we = 1'b1;
                w.u_re = 1'b1; w.usel = US_PARENT; w.lsel = LS_ZERO;
                w.pv_init = 1'b1; w.lvop = LO_INC;
                w.jc = JC_LV_TOP; w.jt = S_A_END;
            end
            S_A_LOOP: begin
                w.a_we = 1'b1; w.a_wchain = 1'b1;
                w.u_re = 1'b1; w.usel = US_CHAIN; w.lsel = LS_LV;
                w.pv_chain = 1'b1; w.lvop = LO_INC;
                w.jc = JC_LV_NTOP; w.jt = S_A_LOOP;
            end
            S_A_END: begin
                w.fin = 1'b1;
            end
            S_Q_RDA: begin
                w.d_re = 1'b1; w.dsel = DS_A;
            end
            S_Q_RDB: begin
                w.d_re = 1'b1; w.dsel = DS_B; w.cap_da = 1'b1;
            end
            S_Q_SWAP: begin
                w.uop = UO_SWAP; w.d_re = 1'b1; w.dsel = DS_UNEXT;
                w.u_re = 1'b1; w.usel = US_NEXT; w.lsel = LS_TOP; w.lvop = LO_TOP;
            end
            S_Q_LIFT: begin
                w.uop = UO_LIFT; w.d_re = 1'b1; w.dsel = DS_UNEXT;
                w.u_re = 1'b1; w.usel = US_NEXT; w.lsel = LS_NEXT; w.lvop = LO_DEC;
                w.jc = JC_LV_NZ; w.jt = S_Q_LIFT;
            end
            S_Q_JSET: begin
                w.cop = CO_U; w.d_re = 1'b1; w.dsel = DS_CNEXT;
                w.u_re = 1'b1; w.usel = US_NEXT; w.v_re = 1'b1;
                w.lsel = LS_TOP; w.lvop = LO_TOP;
                w.jc = JC_SAME; w.jt = S_Q_DIST;
            end
            S_Q_JOINT: begin
                w.uop = UO_JOINT; w.u_re = 1'b1; w.usel = US_NEXT; w.v_re = 1'b1;
                w.lsel = LS_NEXT; w.lvop = LO_DEC;
                w.jc = JC_LV_NZ; w.jt = S_Q_JOINT;
            end
            S_Q_FINAL: begin
                w.cop = CO_FIN; w.d_re = 1'b1; w.dsel = DS_CNEXT;
            end
            S_Q_DIST: begin
                w.emit = 1'b1; w.fin = 1'b1;
            end
            default: begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

    // entry (node, level) sits at node*LEVELS + level
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                   input logic [LV_W-1:0]   lvl);
        return ANC_AW'(32'(node) * LEVELS + 32'(lvl));
    endfunction

endpackage

FILE: hw/rtl/tdlca_ram.sv
module tdlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tree_distance_by_lca.sv
// Channel   Direction  Handshake                      Payload
// input     in         i_in_valid / o_in_stall        i_in_item  (t_in_item)
// output    out        o_out_valid / i_out_stall      o_out_item (t_out_item)
//
// An attach fills the child's ancestor levels; a query lifts the deeper node, then both
// (not when one is an ancestor of the other). Both walk one level of the ancestor table
// per cycle, set by the registered ancestor RAM read that feeds the next address.
// Reset (i_rst_n low, synchronous) clears only control; the root's depth and
// ancestor entries are answered by logic, so no clearing pass runs.
// A finished result waits in the output register while the next item is taken;
// the sequencer holds on its last step only while that register is full and stalled.
module tree_distance_by_lca (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tdlca_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tdlca_pkg::t_out_item o_out_item
);

    import tdlca_pkg::*;

    // sequencer
    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    t_uop            uw;
    logic            adv;
    logic            jump;
    logic            in_acc;
    logic            in_oor;

    // item and walk registers
    logic [NODE_W-1:0] r_a;
    logic [NODE_W-1:0] r_b;
    logic              r_oor;
    logic [NODE_W-1:0] r_u;
    logic [NODE_W-1:0] r_v;
    logic [NODE_W-1:0] r_c;
    logic [DEP_W-1:0]  r_da;
    logic [DEP_W-1:0]  r_db;
    logic [DEP_W-1:0]  r_dv;
    logic [LV_W-1:0]   r_lv;
    logic              r_pv;

    // output register
    logic      r_ovalid;
    t_out_item r_out;

    // RAM side
    logic [DEP_W-1:0]  d_rd;
    logic [ANC_W-1:0]  u_rd;
    logic [ANC_W-1:0]  v_rd;
    logic              r_d_root;
    logic              r_u_root;
    logic              r_v_root;
    logic              r_u_fwd;
    t_anc              r_u_fwd_data;
    logic [DEP_W-1:0]  d_val;
    t_anc              u_val;
    t_anc              v_val;
    t_anc              chain;

    // next values and addresses
    logic [NODE_W-1:0] n_u;
    logic [NODE_W-1:0] n_v;
    logic [NODE_W-1:0] n_c;
    logic [DEP_W-1:0]  n_dv;
    logic              swap;
    logic [DEP_W-1:0]  diff;
    logic              lift;
    logic              move;
    logic [LV_W-1:0]   rd_lv;
    logic [NODE_W-1:0] u_node;
    logic [NODE_W-1:0] d_node;
    logic              d_re;
    logic              d_we;
    logic              a_we;
    logic              u_re;
    logic              v_re;
    logic [ANC_AW-1:0] a_waddr;
    t_anc              a_wdata;
    logic [ANC_AW-1:0] u_raddr;
    logic [ANC_AW-1:0] v_raddr;
    logic [DEP_W-1:0]  dep_sat;
    logic [DEP_W-1:0]  path_len;

    assign in_acc = i_in_valid && !r_busy;
    assign in_oor = (32'(i_in_item.node_a) >= NODES) || (32'(i_in_item.node_b) >= NODES);

    // the control word of the current step; no actions while idle
    assign uw  = r_busy ? uop_rom(r_pc) : '0;
    // hold the emitting step while the output register is full and stalled
    assign adv = !(uw.emit && r_ovalid && i_out_stall);

    always_comb begin
        unique case (uw.jc)
            JC_LV_NZ:   jump = (r_lv != '0);
            JC_LV_TOP:  jump = (r_lv == LV_TOP);
            JC_LV_NTOP: jump = (r_lv != LV_TOP);
            JC_SAME:    jump = (r_u == r_v);
            default:    jump = 1'b0;
        endcase
    end

    // Node 0 is the root: depth zero, no ancestors. It is never written, so
    // override whatever the RAM holds there. A port U read that hits the ancestor
    // entry written in the same cycle takes the written value.
    assign d_val = r_d_root ? '0 : d_rd;
    assign u_val = r_u_root ? '0 : (r_u_fwd ? r_u_fwd_data : t_anc'(u_rd));
    assign v_val = r_v_root ? '0 : t_anc'(v_rd);
    // once an ancestor level is none, every higher level is none
    assign chain = r_pv ? u_val : '0;

    // lift the deeper node by 2^lv when the depth gap allows it
    assign swap = (r_da < d_val);
    assign diff = d_val - r_dv;
    assign lift = (d_val >= r_dv) && (32'(diff) >= (32'd1 << r_lv)) && u_val.valid;
    // move both nodes only when both ancestors exist and differ
    assign move = u_val.valid && v_val.valid && (u_val != v_val);

    always_comb begin
        n_u  = r_u;
        n_v  = r_v;
        n_dv = r_dv;
        unique case (uw.uop)
            UO_SWAP: begin
                n_u  = swap ? r_b : r_a;
                n_v  = swap ? r_a : r_b;
                n_dv = swap ? r_da : d_val;
            end
            UO_LIFT: begin
                n_u = lift ? u_val.node : r_u;
            end
            UO_JOINT: begin
                n_u = move ? u_val.node : r_u;
                n_v = move ? v_val.node : r_v;
            end
            default: begin
                n_u = r_u;
            end
        endcase
    end

    always_comb begin
        unique case (uw.cop)
            CO_U:    n_c = r_u;
            CO_FIN:  n_c = u_val.valid ? u_val.node : r_u;
            default: n_c = r_c;
        endcase
    end

    always_comb begin
        unique case (uw.lsel)
            LS_ZERO: rd_lv = '0;
            LS_LV:   rd_lv = r_lv;
            LS_TOP:  rd_lv = LV_TOP;
            LS_NEXT: rd_lv = (r_lv == '0) ? '0 : r_lv - LV_W'(1);
            default: rd_lv = '0;
        endcase
    end

    always_comb begin
        unique case (uw.usel)
            US_PARENT: u_node = r_b;
            US_CHAIN:  u_node = chain.node;
            US_NEXT:   u_node = n_u;
            default:   u_node = n_u;
        endcase
    end

    always_comb begin
        unique case (uw.dsel)
            DS_A:     d_node = r_a;
            DS_B:     d_node = r_b;
            DS_UNEXT: d_node = n_u;
            DS_CNEXT: d_node = n_c;
            default:  d_node = r_a;
        endcase
    end

    assign d_re = uw.d_re && adv;
    assign d_we = uw.d_we && adv;
    assign a_we = uw.a_we && adv;
    assign u_re = uw.u_re && adv;
    assign v_re = uw.v_re && adv;

    // the child's level lv; level 0 is the parent itself
    assign a_waddr = anc_addr(r_a, r_lv);
    assign a_wdata = uw.a_wchain ? chain : t_anc'{valid: 1'b1, node: r_b};
    assign u_raddr = anc_addr(u_node, rd_lv);
    assign v_raddr = anc_addr(n_v, rd_lv);

    // child depth is parent depth plus one, saturating
    assign dep_sat  = (d_val == {DEP_W{1'b1}}) ? d_val : d_val + DEP_W'(1);
    // wraps mod 2^DEP_W like the distance field
    assign path_len = r_da + r_db - {d_val[DEP_W-2:0], 1'b0};

    tdlca_ram #(
        .WIDTH (DEP_W),
        .DEPTH (NODES)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (NODE_AW'(r_a)),
        .i_wdata (dep_sat),
        .i_re    (d_re),
        .i_raddr (NODE_AW'(d_node)),
        .o_rdata (d_rd)
    );

    // two copies of the ancestor table give the joint walk two read ports
    tdlca_ram #(
        .WIDTH (ANC_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram_u (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (u_re),
        .i_raddr (u_raddr),
        .o_rdata (u_rd)
    );

    tdlca_ram #(
        .WIDTH (ANC_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram_v (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (v_re),
        .i_raddr (v_raddr),
        .o_rdata (v_rd)
    );

    // control: sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pc     <= S_A_RD;
            r_ovalid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_in_item.action == ACT_QUERY) begin
                    // an out-of-range query goes straight to the result step
                    r_busy <= 1'b1;
                    r_pc   <= in_oor ? S_Q_DIST : S_Q_RDA;
                end else if (!in_oor && (i_in_item.node_a != '0)) begin
                    r_busy <= 1'b1;
                    r_pc   <= S_A_RD;
                end
            end else if (r_busy && adv) begin
                r_pc <= jump ? uw.jt : r_pc + PC_W'(1);
                if (uw.fin) begin
                    r_busy <= 1'b0;
                end
            end
            if (uw.emit && adv) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a   <= i_in_item.node_a;
            r_b   <= i_in_item.node_b;
            r_oor <= in_oor;
        end
        if (r_busy && adv) begin
            r_u  <= n_u;
            r_v  <= n_v;
            r_dv <= n_dv;
            r_c  <= n_c;
            if (uw.cap_da) begin
                r_da <= d_val;
            end
            if (uw.uop == UO_SWAP) begin
                r_db <= d_val;
            end
            unique case (uw.lvop)
                LO_ZERO: r_lv <= '0;
                LO_TOP:  r_lv <= LV_TOP;
                LO_INC:  r_lv <= r_lv + LV_W'(1);
                LO_DEC:  r_lv <= r_lv - LV_W'(1);
                default: r_lv <= r_lv;
            endcase
            if (uw.pv_init) begin
                r_pv <= 1'b1;
            end else if (uw.pv_chain) begin
                r_pv <= chain.valid;
            end
        end
        if (d_re) begin
            r_d_root <= (d_node == '0);
        end
        if (u_re) begin
            r_u_root     <= (u_node == '0);
            r_u_fwd      <= a_we && (u_raddr == a_waddr);
            r_u_fwd_data <= a_wdata;
        end
        if (v_re) begin
            r_v_root <= (n_v == '0);
        end
        if (uw.emit && adv) begin
            r_out.distance        <= r_oor ? '0 : path_len;
            r_out.common_ancestor <= r_oor ? '0 : r_c;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

FILE: hw/rtl/tdlca_chk.sv
module tdlca_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input tdlca_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input tdlca_pkg::t_out_item o_out_item
);

    import tdlca_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // every query transfer keeps the block busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.action == ACT_QUERY) |=> o_in_stall)
        else $error("query transfer did not start work");

    // a result only follows work
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without preceding work");

    // work only starts with an input transfer
    a_busy_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("block went busy without an input transfer");

endmodule

bind tree_distance_by_lca tdlca_chk u_chk (.*);

FILE: verif/tb_tree_distance_by_lca.sv
`timescale 1ns / 100ps

module tb_tree_distance_by_lca;

    import tdlca_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 200;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    tree_distance_by_lca dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Shadow copy of the tree: depth per node and the 2^k-th ancestor per level.
    logic [DEP_W-1:0] depth_of [NODES];
    t_anc             lift_of  [NODES][LEVELS];
    // Nodes that have been hung in the tree; only these are ever queried or
    // used as a parent, so no never-written entry gets read.
    bit               hung     [NODES];
    int               hung_q   [$];

    t_out_item   pending_paths [$];
    t_out_item   oldest_path;
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          in_gap_pct     = 25;
    bit          calm_tail      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort on a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void clear_tree();
        foreach (depth_of[n]) begin
            depth_of[n] = '0;
            hung[n]     = 1'b0;
            for (int lv = 0; lv < LEVELS; lv++) begin
                lift_of[n][lv] = t_anc'('0);
            end
        end
        hung[0] = 1'b1;
        hung_q  = {0};
    endfunction

    // Hang child under parent: depth saturates at the top of the range, and
    // each level k is the level k-1 ancestor of the level k-1 ancestor.
    // Descendants of a moved node keep their old entries.
    function automatic void graft_node(logic [NODE_W-1:0] child, logic [NODE_W-1:0] parent);
        t_anc             up;
        logic [DEP_W-1:0] pd;
        pd = depth_of[parent];
        if (child == '0) begin
            return;
        end
        depth_of[child]   = (pd == '1) ? pd : pd + 1'b1;
        lift_of[child][0] = '{valid: 1'b1, node: parent};
        for (int lv = 1; lv < LEVELS; lv++) begin
            up = lift_of[child][lv-1];
            lift_of[child][lv] = up.valid ? lift_of[up.node][lv-1] : t_anc'('0);
        end
        if (!hung[child]) begin
            hung[child] = 1'b1;
            hung_q      = {hung_q, int'(child)};
        end
    endfunction

    // Lift the deeper node to the other's depth, then lift both while their
    // ancestors differ. A step toward a missing ancestor leaves the node put.
    function automatic logic [NODE_W-1:0] meet_of(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] u;
        logic [NODE_W-1:0] v;
        logic [NODE_W-1:0] t;
        t_anc              au;
        t_anc              av;
        int                du;
        int                dv;
        u = a;
        v = b;
        if (depth_of[u] < depth_of[v]) begin
            t = u;
            u = v;
            v = t;
        end
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
            du = depth_of[u];
            dv = depth_of[v];
            if (du >= dv && du - dv >= (1 << lv)) begin
                au = lift_of[u][lv];
                if (au.valid) begin
                    u = au.node;
                end
            end
        end
        if (u == v) begin
            return u;
        end
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
            au = lift_of[u][lv];
            av = lift_of[v][lv];
            if (au.valid && av.valid && au != av) begin
                u = au.node;
                v = av.node;
            end
        end
        // a final node without a parent is its own answer
        au = lift_of[u][0];
        return au.valid ? au.node : u;
    endfunction

    function automatic t_out_item path_of(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        t_out_item         r;
        logic [NODE_W-1:0] c;
        c = meet_of(a, b);
        r.common_ancestor = c;
        // wraps when the tables are stale after a move
        r.distance = DEP_W'(depth_of[a] + depth_of[b] - 2 * depth_of[c]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result check: compare each result transfer with the oldest prediction.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_paths.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual distance %0d ancestor %0d",
                         $time, o_out_item.distance, o_out_item.common_ancestor);
            end else begin
                oldest_path = pending_paths.pop_front();
                if (o_out_item.distance !== oldest_path.distance) begin
                    mismatch_count++;
                    $display("%0t: distance mismatch: expected %0d, actual %0d",
                             $time, oldest_path.distance, o_out_item.distance);
                end
                if (o_out_item.common_ancestor !== oldest_path.common_ancestor) begin
                    mismatch_count++;
                    $display("%0t: common_ancestor mismatch: expected %0d, actual %0d",
                             $time, oldest_path.common_ancestor, o_out_item.common_ancestor);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stall: random bursts of stall and of flow; none in the tail.
    // ------------------------------------------------------------------

    initial begin
        forever begin
            if (calm_tail) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Drive one item and hold it until its transfer, then predict. Valid stays
    // high on return so that back-to-back items need no second assignment.
    task automatic send_item(input t_in_item it);
        if (!calm_tail && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (it.action == ACT_ATTACH) begin
            graft_node(it.node_a, it.node_b);
        end else begin
            pending_paths = {pending_paths, path_of(it.node_a, it.node_b)};
        end
        // vary how often the sender idles so some stretches run with no gaps
        if ($urandom_range(0, 39) == 0) begin
            in_gap_pct = $urandom_range(0, 40);
        end
    endtask

    task automatic attach(input int child, input int parent);
        send_item('{action: ACT_ATTACH, node_a: NODE_W'(child), node_b: NODE_W'(parent)});
    endtask

    task automatic query(input int a, input int b);
        send_item('{action: ACT_QUERY, node_a: NODE_W'(a), node_b: NODE_W'(b)});
    endtask

    // Drop valid and wait for every predicted result to come out.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_paths.size() != 0);
    endtask

    function automatic int any_hung();
        return hung_q[$urandom_range(0, hung_q.size() - 1)];
    endfunction

    // One of the last few nodes hung, to branch near the growing tip.
    function automatic int recent_hung();
        int k;
        k = $urandom_range(0, (hung_q.size() > 8) ? 7 : hung_q.size() - 1);
        return hung_q[hung_q.size() - 1 - k];
    endfunction

    // The hung node with the largest depth, to grow the tree from its tip.
    function automatic int deepest_hung();
        int best;
        best = 0;
        foreach (hung_q[k]) begin
            if (depth_of[hung_q[k]] > depth_of[best]) begin
                best = hung_q[k];
            end
        end
        return best;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of the node fields, the root, ancestor pairs, moves and
    // ignored attaches of the root.
    task automatic test_directed_cases();
        query(0, 0);
        attach(0, 0);         // root attach: ignored
        attach(1, 0);
        attach(2, 1);
        attach(1023, 2);
        attach(512, 0);
        attach(341, 512);
        attach(682, 341);
        attach(1000, 1023);   // parent at the top of the node range
        query(1023, 0);
        query(0, 1000);
        query(1000, 682);
        query(1023, 1023);
        query(2, 1000);       // one node is the other's ancestor
        query(682, 1000);
        attach(2, 682);       // move: 1023 and 1000 keep stale entries
        query(1023, 341);
        query(2, 512);
        attach(0, 1023);      // root attach with another parent: ignored
        query(1023, 2);
        query(1000, 1);
        hold_until_drained();
    endtask

    // Grow long chains with side branches so deep lift levels get used; mix
    // in moves, root attaches and queries on hung nodes only.
    task automatic test_random_tree();
        int roll;
        int sel;
        int child;
        int parent;
        int a;
        int b;
        int last_child;
        last_child = hung_q[hung_q.size() - 1];
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 160 == 159) begin
                hold_until_drained();
            end
            roll = $urandom_range(0, 99);
            if (roll < 58 && hung_q.size() < NODES) begin
                do child = $urandom_range(1, NODES - 1); while (hung[child]);
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    parent = last_child;
                end else if (sel < 95) begin
                    parent = recent_hung();
                end else begin
                    parent = any_hung();
                end
                attach(child, parent);
                last_child = child;
            end else if (roll < 64) begin
                attach(hung_q[$urandom_range(1, hung_q.size() - 1)], any_hung());
            end else if (roll < 66) begin
                attach(0, any_hung());
            end else begin
                a   = any_hung();
                sel = $urandom_range(0, 99);
                if (sel < 20) begin
                    b = last_child;
                end else if (sel < 35) begin
                    b = a;
                end else if (sel < 50) begin
                    b = recent_hung();
                end else begin
                    b = any_hung();
                end
                query(a, b);
            end
        end
        hold_until_drained();
    endtask

    // Bounce two nodes under each other, starting at the deepest node; every
    // move adds one level, until the depth pins at its maximum. Runs with no
    // idling on either side.
    task automatic test_depth_saturation();
        int p;
        int q;
        int t;
        int extra;
        calm_tail = 1'b1;
        q     = deepest_hung();
        p     = (hung_q[1] == q) ? hung_q[2] : hung_q[1];
        extra = (hung_q[3] == q) ? hung_q[4] : hung_q[3];
        do begin
            attach(p, q);
            t = p;
            p = q;
            q = t;
        end while (depth_of[q] != '1);
        attach(p, q);
        attach(q, p);
        attach(extra, p);
        query(p, q);
        query(q, p);
        query(q, 0);
        query(extra, 0);
        query(q, q);
        query(extra, hung_q[4]);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        clear_tree();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_tree();
        test_depth_saturation();

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: tree_distance_by_lca.f
hw/rtl/tdlca_pkg.sv
hw/rtl/tdlca_ram.sv
hw/rtl/tree_distance_by_lca.sv
hw/rtl/tdlca_chk.sv
verif/tb_tree_distance_by_lca.sv
